>>> rtl/core/dtc_pkg.sv
// ----------------------------------------------------------------------------
// Decision tree classifier package
// Shared constants, codes and types for the decision tree classifier core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtc_pkg;

   localparam int MAX_NODES     = 256;
   localparam int MAX_FEATURES  = 1024;
   localparam int VALUE_BITS    = 32;
   localparam int COUNT_BITS    = 32;

   localparam int NODE_BITS     = $clog2(MAX_NODES);
   localparam int FEAT_BITS     = $clog2(MAX_FEATURES);
   localparam int FEAT_IDX_BITS = 11;
   localparam int STEP_BITS     = $clog2(MAX_NODES + 1);
   localparam int CODE_BITS     = 3;

   typedef enum logic [1:0] {
      OP_WRITE_NODE    = 2'd0,
      OP_WRITE_FEATURE = 2'd1,
      OP_CLASSIFY      = 2'd2,
      OP_READ_COUNT    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_LEAF       = 2'd1,
      ST_DEAD_END   = 2'd2,
      ST_STEP_LIMIT = 2'd3
   } status_type;

   typedef enum logic [CODE_BITS-1:0] {
      CMP_LT = 3'd0,
      CMP_LE = 3'd1,
      CMP_GT = 3'd2,
      CMP_GE = 3'd3,
      CMP_EQ = 3'd4
   } compare_type;

   typedef struct packed {
      logic [FEAT_IDX_BITS-1:0] feat;
      logic [NODE_BITS-1:0]     lchild;
      logic [NODE_BITS-1:0]     rchild;
      logic [CODE_BITS-1:0]     lcmp;
      logic [CODE_BITS-1:0]     rcmp;
   } node_entry_type;

endpackage

`default_nettype wire

>>> rtl/core/dtc_compare.sv
// ----------------------------------------------------------------------------
// Decision tree branch compare unit
// Signed compare of a feature value against a threshold under a compare code.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_compare (
   input  wire logic signed [dtc_pkg::VALUE_BITS-1:0] value,
   input  wire logic signed [dtc_pkg::VALUE_BITS-1:0] threshold,
   input  wire logic [dtc_pkg::CODE_BITS-1:0]         code,
   output logic                                        holds
);

   logic less;
   logic equal;

   assign less  = value < threshold;
   assign equal = value == threshold;

   always_comb begin
      unique case (code)
         dtc_pkg::CMP_LT: holds = less;
         dtc_pkg::CMP_LE: holds = less | equal;
         dtc_pkg::CMP_GT: holds = ~(less | equal);
         dtc_pkg::CMP_GE: holds = ~less;
         dtc_pkg::CMP_EQ: holds = equal;
         default:         holds = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/decision_tree_classifier_core.sv
// ----------------------------------------------------------------------------
// Decision tree classifier core
// Node and feature writes go straight to the result state; a count read passes a read
// state. A classify walk takes each inner node through fetch, enter and left test, plus a
// right test if the left fails; a leaf ends after fetch and enter, a step-limit stop after
// an extra fetch, and S_DONE issues the result; one node memory read and one shared compare
// unit set this. A new transaction is accepted once the last result issues. Reset clears
// the control state and the visit counts at once; node and feature stores start undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module decision_tree_classifier_core (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic [1:0]                                req_opcode,
   input  wire logic [7:0]                                req_node_index,
   input  wire logic [10:0]                               req_feature_index,
   input  wire logic [7:0]                                req_left_child,
   input  wire logic [7:0]                                req_right_child,
   input  wire logic [2:0]                                req_left_compare,
   input  wire logic [2:0]                                req_right_compare,
   input  wire logic signed [31:0]                        req_left_threshold,
   input  wire logic signed [31:0]                        req_right_threshold,
   input  wire logic signed [31:0]                        req_feature_value,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [1:0]                                     rsp_status,
   output logic [7:0]                                     rsp_leaf_node,
   output logic [31:0]                                    rsp_visit_count
);

   localparam int NB = dtc_pkg::NODE_BITS;
   localparam int FB = dtc_pkg::FEAT_BITS;
   localparam int VB = dtc_pkg::VALUE_BITS;
   localparam int CB = dtc_pkg::COUNT_BITS;
   localparam int SB = dtc_pkg::STEP_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDCNT,
      S_FETCH,
      S_ENTER,
      S_CMPL,
      S_CMPR,
      S_DONE
   } state_type;

   state_type                  state_ff;
   logic [NB-1:0]              cur_ff;
   logic [SB-1:0]              steps_ff;
   dtc_pkg::status_type        status_ff;
   logic [NB-1:0]              leaf_ff;
   logic [CB-1:0]              count_ff;
   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_status_ff;
   logic [NB-1:0]              rsp_leaf_ff;
   logic [CB-1:0]              rsp_count_ff;

   dtc_pkg::node_entry_type    node_mem [dtc_pkg::MAX_NODES];
   logic [VB-1:0]              lthr_mem [dtc_pkg::MAX_NODES];
   logic [VB-1:0]              rthr_mem [dtc_pkg::MAX_NODES];
   logic [VB-1:0]              feat_mem [dtc_pkg::MAX_FEATURES];
   logic [CB-1:0]              visit_mem [dtc_pkg::MAX_NODES];
   logic [dtc_pkg::MAX_NODES-1:0] visit_vld_ff;

   dtc_pkg::node_entry_type    node_rd_ff;
   logic [VB-1:0]              lthr_rd_ff;
   logic [VB-1:0]              rthr_rd_ff;
   logic [VB-1:0]              feat_rd_ff;
   logic [CB-1:0]              cnt_rd_ff;
   logic                       cnt_vld_rd_ff;

   logic                       req_fire;
   logic                       rsp_free;
   logic [NB-1:0]              cnt_addr;
   logic [CB-1:0]              cnt_cur;
   logic [CB-1:0]              cnt_next;
   logic                       l_ok;
   logic                       r_ok;
   logic                       feat_absent;
   logic signed [VB-1:0]       cmp_value;
   logic signed [VB-1:0]       cmp_threshold;
   logic [dtc_pkg::CODE_BITS-1:0] cmp_code;
   logic                       cmp_holds;

   assign req_stall       = state_ff != S_IDLE;
   assign req_fire        = req_valid && !req_stall;
   assign rsp_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_leaf_node   = rsp_leaf_ff;
   assign rsp_visit_count = rsp_count_ff;

   assign cnt_addr = (state_ff == S_IDLE) ? req_node_index : cur_ff;
   assign cnt_cur  = cnt_vld_rd_ff ? cnt_rd_ff : '0;
   assign cnt_next = (&cnt_cur) ? cnt_cur : cnt_cur + CB'(1);

   assign l_ok = (node_rd_ff.lchild != '0) &&
                 ({1'b0, node_rd_ff.lchild} < (NB+1)'(dtc_pkg::MAX_NODES));
   assign r_ok = (node_rd_ff.rchild != '0) &&
                 ({1'b0, node_rd_ff.rchild} < (NB+1)'(dtc_pkg::MAX_NODES));
   assign feat_absent = node_rd_ff.feat >= dtc_pkg::FEAT_IDX_BITS'(dtc_pkg::MAX_FEATURES);

   assign cmp_value     = feat_absent ? '0 : $signed(feat_rd_ff);
   assign cmp_threshold = (state_ff == S_CMPR) ? $signed(rthr_rd_ff) : $signed(lthr_rd_ff);
   assign cmp_code      = (state_ff == S_CMPR) ? node_rd_ff.rcmp : node_rd_ff.lcmp;

   dtc_compare u_compare (
      .value     (cmp_value),
      .threshold (cmp_threshold),
      .code      (cmp_code),
      .holds     (cmp_holds)
   );

   always_ff @(posedge clock) begin
      if (req_fire && req_opcode == dtc_pkg::OP_WRITE_NODE &&
          {1'b0, req_node_index} < (NB+1)'(dtc_pkg::MAX_NODES)) begin
         node_mem[req_node_index] <= '{feat:   req_feature_index,
                                       lchild: req_left_child,
                                       rchild: req_right_child,
                                       lcmp:   req_left_compare,
                                       rcmp:   req_right_compare};
         lthr_mem[req_node_index] <= req_left_threshold;
         rthr_mem[req_node_index] <= req_right_threshold;
      end
      node_rd_ff <= node_mem[cur_ff];
      lthr_rd_ff <= lthr_mem[cur_ff];
      rthr_rd_ff <= rthr_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_opcode == dtc_pkg::OP_WRITE_FEATURE &&
          req_feature_index < dtc_pkg::FEAT_IDX_BITS'(dtc_pkg::MAX_FEATURES)) begin
         feat_mem[req_feature_index[FB-1:0]] <= req_feature_value;
      end
      feat_rd_ff <= feat_mem[node_rd_ff.feat[FB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ENTER) begin
         visit_mem[cur_ff] <= cnt_next;
      end
      cnt_rd_ff <= visit_mem[cnt_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visit_vld_ff  <= '0;
         cnt_vld_rd_ff <= 1'b0;
      end else begin
         if (state_ff == S_ENTER) begin
            visit_vld_ff[cur_ff] <= 1'b1;
         end
         cnt_vld_rd_ff <= visit_vld_ff[cnt_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  status_ff <= dtc_pkg::ST_DONE;
                  leaf_ff   <= '0;
                  count_ff  <= '0;
                  cur_ff    <= '0;
                  steps_ff  <= '0;
                  unique case (dtc_pkg::opcode_type'(req_opcode))
                     dtc_pkg::OP_WRITE_NODE:    state_ff <= S_DONE;
                     dtc_pkg::OP_WRITE_FEATURE: state_ff <= S_DONE;
                     dtc_pkg::OP_CLASSIFY:      state_ff <= S_FETCH;
                     dtc_pkg::OP_READ_COUNT:    state_ff <= S_RDCNT;
                  endcase
               end
            end
            S_RDCNT: begin
               count_ff <= cnt_cur;
               state_ff <= S_DONE;
            end
            S_FETCH: begin
               if (steps_ff >= SB'(dtc_pkg::MAX_NODES)) begin
                  status_ff <= dtc_pkg::ST_STEP_LIMIT;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_ENTER;
               end
            end
            S_ENTER: begin
               steps_ff <= steps_ff + SB'(1);
               leaf_ff  <= cur_ff;
               if (!l_ok && !r_ok) begin
                  status_ff <= dtc_pkg::ST_LEAF;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_CMPL;
               end
            end
            S_CMPL: begin
               if (l_ok && cmp_holds) begin
                  cur_ff   <= node_rd_ff.lchild;
                  state_ff <= S_FETCH;
               end else begin
                  state_ff <= S_CMPR;
               end
            end
            S_CMPR: begin
               if (r_ok && cmp_holds) begin
                  cur_ff   <= node_rd_ff.rchild;
                  state_ff <= S_FETCH;
               end else begin
                  status_ff <= dtc_pkg::ST_DEAD_END;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_leaf_ff   <= leaf_ff;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= SB'(dtc_pkg::MAX_NODES) || state_ff == S_IDLE)
      else $error("walk step count passed the node limit");

   a_enter_after_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ENTER |-> $past(state_ff) == S_FETCH)
      else $error("node entered without a fetch");

   a_count_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dtc_pkg::ST_DONE |-> rsp_visit_count == '0)
      else $error("classify result carries a visit count");

   a_leaf_only_on_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dtc_pkg::ST_DONE |-> rsp_leaf_node == '0)
      else $error("write or read result carries a leaf node");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && rsp_stall |=> state_ff == S_DONE)
      else $error("finished result dropped while the output was stalled");

endmodule

`default_nettype wire
